// ===== rtl/wildcard_name_matcher_macros.svh =====
// assertion macros for the wildcard name matcher checker
`ifndef WILDCARD_NAME_MATCHER_MACROS_SVH
`define WILDCARD_NAME_MATCHER_MACROS_SVH

// checked only while out of reset
`define WNM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every edge, reset included
`define WNM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/wnm_pkg.sv =====
// shared constants and types of the wildcard name matcher
package wnm_pkg;

  localparam int unsigned PAT_LEN    = 32;
  localparam int unsigned NPOS       = PAT_LEN + 1;
  localparam int unsigned IDX_W      = $clog2(PAT_LEN);
  localparam int unsigned LEN_W      = $clog2(PAT_LEN + 1);
  localparam int unsigned CLOSE_LVLS = $clog2(NPOS);
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DATA_W     = 32;

  localparam logic [7:0] ANY_RUN_RST = 8'd42;
  localparam logic [7:0] SINGLE_RST  = 8'd63;

  localparam logic REG_ANY_RUN = 1'b0;
  localparam logic REG_SINGLE  = 1'b1;

  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_NAME    = 1'b1;

  typedef struct packed {
    logic [7:0] any_run;
    logic [7:0] single;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic close;
    logic capture;
  } dp_cmd_t;

endpackage

// ===== rtl/wnm_regs.sv =====
// configuration registers behind the apb port
module wnm_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [wnm_pkg::ADDR_W-1:0] paddr,
  input  logic [wnm_pkg::DATA_W-1:0] pwdata,
  output logic [wnm_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output wnm_pkg::cfg_t             cfg_o
);

  logic [7:0] any_run_q, any_run_d;
  logic [7:0] single_q, single_d;
  logic       wr_en;
  logic [7:0] rd_byte;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    any_run_d = any_run_q;
    single_d  = single_q;
    if (wr_en) begin
      case (paddr[2])
        wnm_pkg::REG_ANY_RUN: any_run_d = pwdata[7:0];
        wnm_pkg::REG_SINGLE:  single_d  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_run_q <= wnm_pkg::ANY_RUN_RST;
      single_q  <= wnm_pkg::SINGLE_RST;
    end else begin
      any_run_q <= any_run_d;
      single_q  <= single_d;
    end
  end

  always_comb begin
    case (paddr[2])
      wnm_pkg::REG_ANY_RUN: rd_byte = any_run_q;
      wnm_pkg::REG_SINGLE:  rd_byte = single_q;
      default:              rd_byte = any_run_q;
    endcase
  end

  assign prdata        = {{(wnm_pkg::DATA_W-8){1'b0}}, rd_byte} &
                         {wnm_pkg::DATA_W{paddr[1:0] == 2'b00}};
  assign cfg_o.any_run = any_run_q;
  assign cfg_o.single  = single_q;

endmodule

// ===== rtl/wnm_ctrl.sv =====
// controller: transfer handshakes and closure/result sequencing
module wnm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic              is_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wnm_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_CLOSE = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign slot_free   = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    pend_d        = pend_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    cmd_o.load    = 1'b0;
    cmd_o.step    = 1'b0;
    cmd_o.close   = 1'b0;
    cmd_o.capture = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_o.load = (kind_i == wnm_pkg::KIND_PATTERN);
          cmd_o.step = (kind_i == wnm_pkg::KIND_NAME);
          pend_d     = (kind_i == wnm_pkg::KIND_NAME) & is_last_i;
          state_d    = S_CLOSE;
        end
      end
      S_CLOSE: begin
        cmd_o.close = 1'b1;
        if (pend_q) begin
          // result goes out, then one more pass closes the restarted vector
          if (slot_free) begin
            cmd_o.capture = 1'b1;
            out_valid_d   = 1'b1;
            pend_d        = 1'b0;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        pend_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/wnm_dp.sv =====
// datapath: pattern store, active position vector, closure unit, result register
module wnm_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wnm_pkg::cfg_t     cfg_i,
  input  wnm_pkg::dp_cmd_t  cmd_i,
  input  logic [7:0]        byte_value_i,
  input  logic              is_last_i,
  output logic              matched_o,
  output logic              pattern_too_long_o
);

  logic [7:0]                pat_q [wnm_pkg::PAT_LEN];
  logic [wnm_pkg::LEN_W-1:0] len_q, len_d;
  logic                      fresh_q, fresh_d;
  logic                      pclosed_q, pclosed_d;
  logic                      ovf_q, ovf_d;
  logic [wnm_pkg::NPOS-1:0]  act_q, act_d;
  logic                      ended_q, ended_d;
  logic                      matched_q, matched_d;
  logic                      ptl_q, ptl_d;

  logic [wnm_pkg::PAT_LEN-1:0] in_len, is_star, is_hit;
  logic [wnm_pkg::NPOS-1:0]    adv_vec, closed_vec, restart_vec;
  logic [wnm_pkg::LEN_W-1:0]   eff_len;
  logic                        eff_closed, eff_ovf;
  logic                        wr_en;

  assign restart_vec = {{(wnm_pkg::NPOS-1){1'b0}}, 1'b1};

  // per-position compares
  always_comb begin
    for (int i = 0; i < wnm_pkg::PAT_LEN; i++) begin
      in_len[i]  = wnm_pkg::LEN_W'(i) < len_q;
      is_star[i] = pat_q[i] == cfg_i.any_run;
      is_hit[i]  = (pat_q[i] == cfg_i.single) | (pat_q[i] == byte_value_i);
    end
  end

  // one name byte keeps, advances or drops each active position
  always_comb begin
    adv_vec = '0;
    for (int i = 0; i < wnm_pkg::PAT_LEN; i++) begin
      if (act_q[i] & in_len[i]) begin
        if (is_star[i]) begin
          adv_vec[i] = 1'b1;
        end else if (is_hit[i]) begin
          adv_vec[i+1] = 1'b1;
        end
      end
    end
  end

  // closure over runs of any-run bytes, prefix doubling
  always_comb begin
    logic [wnm_pkg::NPOS-1:0] a_v;
    logic [wnm_pkg::NPOS-1:0] p_v;
    a_v = act_q;
    p_v = {is_star & in_len, 1'b0};
    for (int l = 0; l < wnm_pkg::CLOSE_LVLS; l++) begin
      a_v = a_v | ((a_v << (1 << l)) & p_v);
      p_v = p_v & (p_v << (1 << l));
    end
    closed_vec = a_v;
  end

  assign eff_len    = fresh_q ? '0 : len_q;
  assign eff_closed = fresh_q ? 1'b0 : pclosed_q;
  assign eff_ovf    = fresh_q ? 1'b0 : ovf_q;
  assign wr_en      = cmd_i.load & ~eff_closed & (byte_value_i != 8'd0) &
                      (eff_len < wnm_pkg::LEN_W'(wnm_pkg::PAT_LEN));

  always_comb begin
    len_d     = len_q;
    fresh_d   = fresh_q;
    pclosed_d = pclosed_q;
    ovf_d     = ovf_q;
    act_d     = act_q;
    ended_d   = ended_q;
    matched_d = matched_q;
    ptl_d     = ptl_q;
    if (cmd_i.load) begin
      len_d     = eff_len;
      pclosed_d = eff_closed;
      ovf_d     = eff_ovf;
      if (!eff_closed) begin
        if (byte_value_i == 8'd0) begin
          pclosed_d = 1'b1;
        end else if (wr_en) begin
          len_d = eff_len + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
      end
      fresh_d = is_last_i;
      act_d   = restart_vec;
      ended_d = 1'b0;
    end
    if (cmd_i.step && !ended_q) begin
      if (byte_value_i == 8'd0) begin
        ended_d = 1'b1;
      end else begin
        act_d = adv_vec;
      end
    end
    if (cmd_i.close) begin
      if (cmd_i.capture) begin
        matched_d = ~ovf_q & closed_vec[len_q];
        ptl_d     = ovf_q;
        act_d     = restart_vec;
        ended_d   = 1'b0;
      end else begin
        act_d = closed_vec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      fresh_q   <= 1'b1;
      pclosed_q <= 1'b0;
      ovf_q     <= 1'b0;
      act_q     <= {{(wnm_pkg::NPOS-1){1'b0}}, 1'b1};
      ended_q   <= 1'b0;
    end else begin
      len_q     <= len_d;
      fresh_q   <= fresh_d;
      pclosed_q <= pclosed_d;
      ovf_q     <= ovf_d;
      act_q     <= act_d;
      ended_q   <= ended_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
    ptl_q     <= ptl_d;
    if (wr_en) begin
      pat_q[eff_len[wnm_pkg::IDX_W-1:0]] <= byte_value_i;
    end
  end

  assign matched_o          = matched_q;
  assign pattern_too_long_o = ptl_q;

endmodule

// ===== rtl/wildcard_name_matcher.sv =====
// top level of the wildcard name matcher
//
//  channel  | dir | handshake           | payload
//  in       | in  | in_valid_i/ready_o  | kind_i, byte_value_i, is_last_i
//  out      | out | out_valid_o/ready_i | matched_o, pattern_too_long_o
//  config   | in  | apb psel/penable    | any_run_char @0x0, single_char @0x4
//
// pattern bytes and non-final name bytes are accepted, then given one closure pass
// a final name byte is accepted, waits for the output register to free, then captures and closes the restarted vector
// the closure unit covers PAT_LEN+1 bits with a combinational prefix-doubling pass
// reset: empty pattern, wildcards 42 and 63, no result pending
// a held output register stalls only a final name byte, in its closure cycle
module wildcard_name_matcher (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       kind_i,
  input  logic [7:0]                 byte_value_i,
  input  logic                       is_last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       matched_o,
  output logic                       pattern_too_long_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wnm_pkg::ADDR_W-1:0] paddr,
  input  logic [wnm_pkg::DATA_W-1:0] pwdata,
  output logic [wnm_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  wnm_pkg::cfg_t    cfg;
  wnm_pkg::dp_cmd_t cmd;

  wnm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wnm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  wnm_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (cmd),
    .byte_value_i       (byte_value_i),
    .is_last_i          (is_last_i),
    .matched_o          (matched_o),
    .pattern_too_long_o (pattern_too_long_o)
  );

endmodule

// ===== rtl/wnm_checker.sv =====
// port-level assertions for the wildcard name matcher, bound to the top level
`include "wildcard_name_matcher_macros.svh"

module wnm_port_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic matched_o,
  input logic pattern_too_long_o
);

  `WNM_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(matched_o) &&
    $stable(pattern_too_long_o), "stalled result changed")
  `WNM_ASSERT(a_overflow_no_match, clk_i, rst_ni,
    out_valid_o && pattern_too_long_o |-> !matched_o, "overflowed pattern reported a match")
  `WNM_ASSERT(a_busy_after_transfer, clk_i, rst_ni,
    in_valid_i && in_ready_o |=> !in_ready_o, "input taken in the cycle after a transfer")
  `WNM_ASSERT(a_result_while_busy, clk_i, rst_ni,
    $rose(out_valid_o) |-> !in_ready_o, "result appeared while idle")
  `WNM_ASSERT_ALWAYS(a_reset_quiet, clk_i,
    !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind wildcard_name_matcher wnm_port_checker u_wnm_checker (.*);
